// ===== hdl/bsd_pkg.sv =====
// Shared types and constants of the BMP stream decoder.
// No dependencies; every other file of the decoder but bsd_if imports this package.
package bsd_pkg;

  localparam int PAL_ENTRIES    = 256;
  localparam int PAL_AW         = 8;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [7:0]  SIG_B       = 8'h42;
  localparam logic [7:0]  SIG_M       = 8'h4D;
  localparam logic [31:0] INFO_LONG   = 32'd40;
  localparam logic [31:0] INFO_SHORT  = 32'd12;
  localparam logic [15:0] DEPTH_TRUE  = 16'd24;
  localparam logic [15:0] DEPTH_PAL   = 16'd8;

  // header end and palette end for the long and short info header
  localparam logic [31:0] HEND_LONG   = 32'd54;
  localparam logic [31:0] HEND_SHORT  = 32'd26;
  localparam logic [31:0] PEND_LONG   = HEND_LONG + 32'(PAL_ENTRIES * 4);
  localparam logic [31:0] PEND_SHORT  = HEND_SHORT + 32'(PAL_ENTRIES * 3);

  // header byte positions that carry a field's last byte
  localparam logic [31:0] POS_SIG0     = 32'd0;
  localparam logic [31:0] POS_SIG1     = 32'd1;
  localparam logic [31:0] POS_OFFSET   = 32'd13;
  localparam logic [31:0] POS_INFO     = 32'd17;
  localparam logic [31:0] POS_W_LONG   = 32'd21;
  localparam logic [31:0] POS_H_LONG   = 32'd25;
  localparam logic [31:0] POS_D_LONG   = 32'd29;
  localparam logic [31:0] POS_W_SHORT  = 32'd19;
  localparam logic [31:0] POS_H_SHORT  = 32'd21;
  localparam logic [31:0] POS_D_SHORT  = 32'd25;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_SIG    = 3'd1,
    ERR_HDR    = 3'd2,
    ERR_DEPTH  = 3'd3,
    ERR_OFFSET = 3'd4,
    ERR_SIZE   = 3'd5
  } err_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    logic        emit;
    logic        kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] file_row;
    logic        top_down;
    logic        last;
    logic [2:0]  err;
    logic        use_lut;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] idx;
    logic [1:0]        lane;
    logic [7:0]        data;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] idx;
  } pal_rd_t;

endpackage

// ===== hdl/bsd_if.sv =====
// Valid/ready channel interfaces of the BMP stream decoder.
// No dependencies.
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       file_start;
  modport source (output valid, byte_value, file_start, input ready);
  modport sink   (input valid, byte_value, file_start, output ready);
endinterface

interface bsd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] column;
  logic [11:0] file_row;
  logic        top_down;
  logic        last_pixel;
  logic [2:0]  error_code;
  modport source (output valid, result_kind, red, green, blue, column, file_row,
                  top_down, last_pixel, error_code, input ready);
  modport sink   (input valid, result_kind, red, green, blue, column, file_row,
                  top_down, last_pixel, error_code, output ready);
endinterface

// ===== hdl/bsd_palette.sv =====
// Palette memory: 256 entries of B,G,R byte lanes, one lane write and one
// registered read per cycle. Depends on bsd_pkg.
module bsd_palette import bsd_pkg::*; (
  input  logic        clk,
  input  pal_wr_t     wr,
  input  pal_rd_t     rd,
  output logic [23:0] rd_data
);

  logic [7:0] mem_b [PAL_ENTRIES];
  logic [7:0] mem_g [PAL_ENTRIES];
  logic [7:0] mem_r [PAL_ENTRIES];
  logic [23:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      case (wr.lane)
        2'd0:    mem_b[wr.idx] <= wr.data;
        2'd1:    mem_g[wr.idx] <= wr.data;
        2'd2:    mem_r[wr.idx] <= wr.data;
        default: ;
      endcase
    end
    if (rd.en) begin
      rd_data_r <= {mem_r[rd.idx], mem_g[rd.idx], mem_b[rd.idx]};
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/bsd_parser.sv =====
// Byte parser of the BMP stream decoder: header checks, palette fill, offset
// skip and pixel assembly. Depends on bsd_pkg.
module bsd_parser import bsd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] byte_value,
  input  logic       file_start,
  input  logic       keep_index,
  output res_t       res,
  output pal_wr_t    pal_wr,
  output pal_rd_t    pal_rd
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RBW = $clog2(3 * MAX_WIDTH + 4);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_BODY   = 6'b000100,
    PH_PIXELS = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_HALTED = 6'b100000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [31:0]     pos_r, pos_nxt, offset_r, offset_nxt, wacc_r, wacc_nxt;
  logic            long_r, long_nxt, true_r, true_nxt, top_r, top_nxt;
  logic            wok_r, wok_nxt;
  logic [WW-1:0]   width_r, width_nxt, col_r, col_nxt;
  logic [HW-1:0]   height_r, height_nxt, row_r, row_nxt;
  logic [RBW-1:0]  rbc_r, rbc_nxt;
  logic [1:0]      k_r, k_nxt, psub_r, psub_nxt;
  logic [PAL_AW-1:0] pidx_r, pidx_nxt;
  logic [15:0]     hold_r, hold_nxt;

  always_comb begin
    phase_t        ph;
    logic          fail, do_pix, emit, last;
    err_t          code;
    logic [31:0]   pos, wcand, hcand, mag, pend, hend;
    logic [15:0]   dep;
    logic [RBW-1:0] rowdata, padded, rbc_inc;

    // restart on file start, then treat the byte as header byte 0
    ph         = file_start ? PH_HEADER : phase_r;
    pos        = file_start ? 32'd0 : pos_r;
    offset_nxt = file_start ? 32'd0 : offset_r;
    wacc_nxt   = file_start ? 32'd0 : wacc_r;
    long_nxt   = file_start ? 1'b0 : long_r;
    true_nxt   = file_start ? 1'b0 : true_r;
    top_nxt    = file_start ? 1'b0 : top_r;
    wok_nxt    = file_start ? 1'b0 : wok_r;
    width_nxt  = file_start ? '0 : width_r;
    height_nxt = file_start ? '0 : height_r;
    col_nxt    = file_start ? '0 : col_r;
    row_nxt    = file_start ? '0 : row_r;
    rbc_nxt    = file_start ? '0 : rbc_r;
    k_nxt      = file_start ? 2'd0 : k_r;
    psub_nxt   = file_start ? 2'd0 : psub_r;
    pidx_nxt   = file_start ? '0 : pidx_r;
    hold_nxt   = file_start ? 16'd0 : hold_r;
    phase_nxt  = ph;
    pos_nxt    = pos;
    fail       = 1'b0;
    do_pix     = 1'b0;
    emit       = 1'b0;
    last       = 1'b0;
    code       = ERR_NONE;
    wcand      = '0;
    hcand      = '0;
    mag        = '0;
    dep        = '0;
    res        = '0;
    pal_wr     = '0;
    pal_rd     = '0;
    rowdata    = '0;
    padded     = '0;
    rbc_inc    = '0;
    hend       = long_nxt ? HEND_LONG : HEND_SHORT;
    pend       = true_nxt ? hend : (long_nxt ? PEND_LONG : PEND_SHORT);

    case (ph)
      PH_HEADER: begin
        wacc_nxt = {byte_value, wacc_nxt[31:8]};
        if (pos == POS_SIG0 && byte_value != SIG_B) begin
          fail = 1'b1; code = ERR_SIG;
        end
        if (pos == POS_SIG1 && byte_value != SIG_M) begin
          fail = 1'b1; code = ERR_SIG;
        end
        if (pos == POS_OFFSET) offset_nxt = wacc_nxt;
        if (pos == POS_INFO) begin
          if (wacc_nxt == INFO_LONG) long_nxt = 1'b1;
          else if (wacc_nxt == INFO_SHORT) long_nxt = 1'b0;
          else begin
            fail = 1'b1; code = ERR_HDR;
          end
        end
        wcand = long_nxt ? wacc_nxt : {{16{wacc_nxt[31]}}, wacc_nxt[31:16]};
        hcand = wcand;
        if (pos > POS_INFO) begin
          if (pos == (long_nxt ? POS_W_LONG : POS_W_SHORT)) begin
            width_nxt = wcand[WW-1:0];
            wok_nxt   = !wcand[31] && wcand != 32'd0 && wcand <= 32'(MAX_WIDTH);
          end
          if (pos == (long_nxt ? POS_H_LONG : POS_H_SHORT)) begin
            top_nxt = hcand[31];
            mag     = hcand[31] ? (32'd0 - hcand) : hcand;
            if (!wok_nxt || mag == 32'd0 || mag > 32'(MAX_HEIGHT)) begin
              fail = 1'b1; code = ERR_SIZE;
            end else begin
              height_nxt = mag[HW-1:0];
            end
          end
          if (pos == (long_nxt ? POS_D_LONG : POS_D_SHORT)) begin
            dep = wacc_nxt[31:16];
            if (dep == DEPTH_TRUE) true_nxt = 1'b1;
            else if (dep == DEPTH_PAL) true_nxt = 1'b0;
            else begin
              fail = 1'b1; code = ERR_DEPTH;
            end
            pend = true_nxt ? hend : (long_nxt ? PEND_LONG : PEND_SHORT);
            if (!fail && offset_nxt < pend) begin
              fail = 1'b1; code = ERR_OFFSET;
            end
          end
        end
        if (fail) begin
          phase_nxt = PH_HALTED;
          res.emit  = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = code;
        end else begin
          pos_nxt = pos + 32'd1;
          if (pos_nxt >= hend && pos >= POS_INFO) phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (pos < pend) begin
          // palette byte: B,G,R lanes, skip the reserved byte of long entries
          if (psub_nxt != 2'd3) begin
            pal_wr.en   = acc;
            pal_wr.idx  = pidx_nxt;
            pal_wr.lane = psub_nxt;
            pal_wr.data = byte_value;
          end
          if (psub_nxt == (long_nxt ? 2'd3 : 2'd2)) begin
            psub_nxt = 2'd0;
            pidx_nxt = pidx_nxt + 1'b1;
          end else begin
            psub_nxt = psub_nxt + 2'd1;
          end
          pos_nxt = pos + 32'd1;
        end else if (pos < offset_nxt) begin
          pos_nxt = pos + 32'd1;
        end else begin
          phase_nxt = PH_PIXELS;
          do_pix    = 1'b1;
        end
      end
      PH_PIXELS: do_pix = 1'b1;
      default: ;
    endcase

    if (do_pix) begin
      rowdata = true_nxt ? (RBW'(width_nxt) + RBW'({width_nxt, 1'b0})) : RBW'(width_nxt);
      padded  = (rowdata + RBW'(3)) & ~RBW'(3);
      if (rbc_nxt < rowdata) begin
        if (!true_nxt) begin
          emit = 1'b1;
          if (keep_index) begin
            res.red = byte_value;
          end else begin
            res.use_lut = 1'b1;
            pal_rd.en   = acc;
            pal_rd.idx  = byte_value;
          end
        end else begin
          case (k_nxt)
            2'd0: begin
              hold_nxt = {8'd0, byte_value};
              k_nxt    = 2'd1;
            end
            2'd1: begin
              hold_nxt = {byte_value, hold_nxt[7:0]};
              k_nxt    = 2'd2;
            end
            default: begin
              emit      = 1'b1;
              res.red   = byte_value;
              res.green = hold_nxt[15:8];
              res.blue  = hold_nxt[7:0];
              k_nxt     = 2'd0;
            end
          endcase
        end
      end
      if (emit) begin
        last = ((WW+1)'(col_nxt) + 1'b1 == (WW+1)'(width_nxt)) &&
               ((HW+1)'(row_nxt) + 1'b1 == (HW+1)'(height_nxt));
        res.emit     = 1'b1;
        res.kind     = KIND_PIXEL;
        res.column   = 12'(col_nxt);
        res.file_row = 12'(row_nxt);
        res.top_down = top_nxt;
        res.last     = last;
        col_nxt      = col_nxt + 1'b1;
        if (last) phase_nxt = PH_DONE;
      end
      if (!last) begin
        rbc_inc = rbc_nxt + 1'b1;
        if (rbc_inc >= padded) begin
          rbc_nxt = '0;
          col_nxt = '0;
          row_nxt = row_nxt + 1'b1;
          k_nxt   = 2'd0;
        end else begin
          rbc_nxt = rbc_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      offset_r <= '0;
      wacc_r   <= '0;
      long_r   <= 1'b0;
      true_r   <= 1'b0;
      top_r    <= 1'b0;
      wok_r    <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      rbc_r    <= '0;
      k_r      <= '0;
      psub_r   <= '0;
      pidx_r   <= '0;
      hold_r   <= '0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      offset_r <= offset_nxt;
      wacc_r   <= wacc_nxt;
      long_r   <= long_nxt;
      true_r   <= true_nxt;
      top_r    <= top_nxt;
      wok_r    <= wok_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rbc_r    <= rbc_nxt;
      k_r      <= k_nxt;
      psub_r   <= psub_nxt;
      pidx_r   <= pidx_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule

// ===== hdl/bmp_stream_decoder.sv =====
// Top level of the BMP stream decoder: parser, palette memory and output
// register. Depends on bsd_pkg, bsd_if, bsd_parser and bsd_palette.
//
// The decoder takes a BMP file one byte per clock on in_bus (file_start marks
// byte 0 of a file) and gives one result per pixel, or one error result, on
// out_bus. It accepts a byte in every cycle in which the output register is
// empty or being drained, so a stream runs at one byte per cycle; each result
// is registered in the cycle after its byte. At depth 8 the color comes from
// the 256-entry palette memory unless keep_index is set; its single registered
// read port is read in the cycle the index byte is accepted and lands with the
// result. keep_index is sampled at each pixel byte; write it only between
// files. After an error or the last pixel, bytes are dropped until the next
// file start; a file start mid-file restarts parsing and keeps the palette.
module bmp_stream_decoder import bsd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_data,
  bsd_in_if.sink      in_bus,
  bsd_out_if.source   out_bus
);

  logic        keep_index_r;
  logic        acc;
  res_t        res;
  res_t        ores_r;
  logic        ov_r;
  pal_wr_t     pal_wr;
  pal_rd_t     pal_rd;
  logic [23:0] pal_data;

  // hold keep_index from the configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_index_r <= 1'b0;
    end else if (cfg_we) begin
      keep_index_r <= cfg_data;
    end
  end

  // take a new request whenever the output register is free or drains now
  assign in_bus.ready = !ov_r || out_bus.ready;
  assign acc          = in_bus.valid && in_bus.ready;

  bsd_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .byte_value (in_bus.byte_value),
    .file_start (in_bus.file_start),
    .keep_index (keep_index_r),
    .res        (res),
    .pal_wr     (pal_wr),
    .pal_rd     (pal_rd)
  );

  bsd_palette u_palette (
    .clk     (clk),
    .wr      (pal_wr),
    .rd      (pal_rd),
    .rd_data (pal_data)
  );

  // output register: advance on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      ores_r <= '0;
    end else if (acc) begin
      ov_r   <= res.emit;
      ores_r <= res;
    end else if (out_bus.ready) begin
      ov_r   <= 1'b0;
    end
  end

  // palette data stays put while stalled: the memory is read only on accept
  assign out_bus.valid       = ov_r;
  assign out_bus.result_kind = ores_r.kind;
  assign out_bus.red         = ores_r.use_lut ? pal_data[23:16] : ores_r.red;
  assign out_bus.green       = ores_r.use_lut ? pal_data[15:8]  : ores_r.green;
  assign out_bus.blue        = ores_r.use_lut ? pal_data[7:0]   : ores_r.blue;
  assign out_bus.column      = ores_r.column;
  assign out_bus.file_row    = ores_r.file_row;
  assign out_bus.top_down    = ores_r.top_down;
  assign out_bus.last_pixel  = ores_r.last;
  assign out_bus.error_code  = ores_r.err;

endmodule

// ===== dv/bmp_stream_decoder_tb.sv =====
// Self-checking testbench for bmp_stream_decoder: builds BMP byte streams, predicts each result.
// Depends on hdl/bsd_pkg.sv, hdl/bsd_if.sv and the decoder RTL.
module bmp_stream_decoder_tb;
  import bsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] file_row;
    logic        top_down;
    logic        last_pixel;
    logic [2:0]  error_code;
  } decode_result_t;

  typedef struct packed {
    logic [7:0] value;
    logic       first;
  } file_byte_t;

  typedef enum int {
    PARSE_IDLE, PARSE_HEADER, PARSE_BODY, PARSE_PIXELS, PARSE_DONE, PARSE_HALTED
  } parse_phase_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;

  bsd_in_if  in_bus ();
  bsd_out_if out_bus ();

  bmp_stream_decoder i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Byte streams waiting to be sent, and the results they will cause, oldest first.
  file_byte_t     pending_bytes[$];
  decode_result_t expected_results[$];

  int mismatch_cnt;
  int pixel_cnt;
  int error_cnt;
  int file_cnt;
  int bytes_sent;
  int bytes_queued;

  // ---------------------------------------------------------------------------
  // Decoder shadow state: mirrors the parser, the palette and keep_index.
  // ---------------------------------------------------------------------------
  parse_phase_t shadow_phase;
  logic [31:0]  shadow_pos;
  logic [31:0]  shadow_offset;
  logic         shadow_long;
  logic [31:0]  shadow_width;
  logic [31:0]  shadow_height;
  logic         shadow_top_down;
  logic         shadow_true_color;
  logic [23:0]  shadow_palette[PAL_ENTRIES];
  logic [31:0]  shadow_col;
  logic [31:0]  shadow_row;
  logic [31:0]  shadow_row_bytes;
  logic [15:0]  shadow_holder;
  logic [31:0]  shadow_word;
  logic         shadow_keep_index;

  function automatic void restart_parse();
    shadow_phase      = PARSE_HEADER;
    shadow_pos        = '0;
    shadow_offset     = '0;
    shadow_long       = 1'b0;
    shadow_width      = '0;
    shadow_height     = '0;
    shadow_top_down   = 1'b0;
    shadow_true_color = 1'b0;
    shadow_col        = '0;
    shadow_row        = '0;
    shadow_row_bytes  = '0;
    shadow_holder     = '0;
    shadow_word       = '0;
  endfunction

  function automatic logic [31:0] header_end();
    return shadow_long ? HEND_LONG : HEND_SHORT;
  endfunction

  function automatic logic [31:0] palette_end();
    if (shadow_true_color) return header_end();
    return shadow_long ? PEND_LONG : PEND_SHORT;
  endfunction

  function automatic bit raise_error(input err_t code, output decode_result_t r);
    shadow_phase = PARSE_HALTED;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return 1'b1;
  endfunction

  function automatic bit check_size(input logic [31:0] w, input logic [31:0] h,
                                    output decode_result_t r);
    logic [31:0] mag;
    shadow_top_down = h[31];
    mag = h[31] ? -h : h;
    if (w[31] || w == 0 || w > DEF_MAX_WIDTH) return raise_error(ERR_SIZE, r);
    if (mag == 0 || mag > DEF_MAX_HEIGHT) return raise_error(ERR_SIZE, r);
    shadow_width  = w;
    shadow_height = mag;
    return 1'b0;
  endfunction

  function automatic bit check_depth(input logic [15:0] d, output decode_result_t r);
    if (d == DEPTH_TRUE) shadow_true_color = 1'b1;
    else if (d == DEPTH_PAL) shadow_true_color = 1'b0;
    else return raise_error(ERR_DEPTH, r);
    if (shadow_offset < palette_end()) return raise_error(ERR_OFFSET, r);
    return 1'b0;
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic bit header_step(input logic [7:0] b, output decode_result_t r);
    logic [31:0] p;
    p = shadow_pos;
    r = '0;
    shadow_word = {b, shadow_word[31:8]};
    if (p == POS_SIG0 && b != SIG_B) return raise_error(ERR_SIG, r);
    if (p == POS_SIG1 && b != SIG_M) return raise_error(ERR_SIG, r);
    if (p == POS_OFFSET) shadow_offset = shadow_word;
    if (p == POS_INFO) begin
      if (shadow_word == INFO_LONG) shadow_long = 1'b1;
      else if (shadow_word == INFO_SHORT) shadow_long = 1'b0;
      else return raise_error(ERR_HDR, r);
    end
    if (p > POS_INFO) begin
      if (shadow_long) begin
        if (p == POS_W_LONG) shadow_width = shadow_word;
        if (p == POS_H_LONG && check_size(shadow_width, shadow_word, r)) return 1'b1;
        if (p == POS_D_LONG && check_depth(shadow_word[31:16], r)) return 1'b1;
      end else begin
        if (p == POS_W_SHORT) shadow_width = sext16(shadow_word[31:16]);
        if (p == POS_H_SHORT && check_size(shadow_width, sext16(shadow_word[31:16]), r))
          return 1'b1;
        if (p == POS_D_SHORT && check_depth(shadow_word[31:16], r)) return 1'b1;
      end
    end
    shadow_pos = p + 1;
    if (shadow_pos >= header_end() && p >= POS_INFO) shadow_phase = PARSE_BODY;
    return 1'b0;
  endfunction

  function automatic bit pixel_step(input logic [7:0] b, output decode_result_t r);
    logic [31:0] row_data;
    logic [31:0] padded;
    logic [31:0] p;
    logic [23:0] entry;
    bit          emit;
    bit          last;
    bit          got;
    r = '0;
    got = 1'b0;
    row_data = shadow_width * (shadow_true_color ? 3 : 1);
    padded = (row_data + 3) & ~32'd3;
    p = shadow_row_bytes;
    emit = 1'b0;
    if (p < row_data) begin
      if (!shadow_true_color) begin
        if (shadow_keep_index) begin
          r.red = b;
        end else begin
          entry = shadow_palette[b];
          {r.red, r.green, r.blue} = entry;
        end
        emit = 1'b1;
      end else begin
        case (p % 3)
          0: shadow_holder = {8'h00, b};
          1: shadow_holder = {b, shadow_holder[7:0]};
          default: begin
            r.red = b;
            r.green = shadow_holder[15:8];
            r.blue = shadow_holder[7:0];
            emit = 1'b1;
          end
        endcase
      end
      if (emit) begin
        last = (shadow_col + 1 == shadow_width) && (shadow_row + 1 == shadow_height);
        r.kind = KIND_PIXEL;
        r.column = shadow_col[11:0];
        r.file_row = shadow_row[11:0];
        r.top_down = shadow_top_down;
        r.last_pixel = last;
        r.error_code = ERR_NONE;
        shadow_col++;
        got = 1'b1;
        if (last) begin
          shadow_phase = PARSE_DONE;
          return 1'b1;
        end
      end
    end
    shadow_row_bytes = p + 1;
    if (shadow_row_bytes >= padded) begin
      shadow_row_bytes = '0;
      shadow_col = '0;
      shadow_row++;
    end
    return got;
  endfunction

  // Advance the shadow decoder by one accepted byte; return 1 when a result is due.
  function automatic bit predict_byte(input logic [7:0] b, input logic first,
                                      output decode_result_t r);
    logic [31:0] p;
    logic [31:0] rel;
    logic [31:0] stride;
    logic [7:0]  idx;
    int          lane;
    r = '0;
    if (first) restart_parse();
    if (shadow_phase == PARSE_HEADER) return header_step(b, r);
    if (shadow_phase == PARSE_BODY) begin
      p = shadow_pos;
      if (p < palette_end()) begin
        // palette entries arrive blue, green, red, then, in long entries, an ignored pad byte
        stride = shadow_long ? 4 : 3;
        rel = p - header_end();
        idx = 8'(rel / stride);
        lane = int'(rel % stride);
        if (lane < 3) shadow_palette[idx][8*lane +: 8] = b;
        shadow_pos = p + 1;
        return 1'b0;
      end
      if (p < shadow_offset) begin
        shadow_pos = p + 1;
        return 1'b0;
      end
      shadow_phase = PARSE_PIXELS;
    end
    if (shadow_phase == PARSE_PIXELS) return pixel_step(b, r);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] v, input logic first);
    file_byte_t fb;
    fb.value = v;
    fb.first = first;
    pending_bytes.push_back(fb);
    bytes_queued++;
  endfunction

  function automatic void push_word(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) push_byte(v[8*i +: 8], 1'b0);
  endfunction

  function automatic void push_noise(input int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'b0);
  endfunction

  // Build one file. sig_bad corrupts 'B' (1) or 'M' (2); pix_keep < 0 sends all
  // pixel data, otherwise at most pix_keep bytes of it; junk trails the file.
  function automatic void build_file(input bit long_f, input int w, input int h,
                                     input int depth, input int info, input int gap,
                                     input int off_adj, input int sig_bad,
                                     input int pix_keep, input int junk);
    int hend;
    int pend;
    int off;
    int row_data;
    int total;
    hend = long_f ? HEND_LONG : HEND_SHORT;
    pend = (depth == DEPTH_PAL) ? (long_f ? PEND_LONG : PEND_SHORT) : hend;
    off  = pend + gap + off_adj;
    push_byte((sig_bad == 1) ? 8'h41 : SIG_B, 1'b1);
    push_byte((sig_bad == 2) ? 8'h4E : SIG_M, 1'b0);
    push_noise(8);
    push_word(off, 4);
    push_word(info, 4);
    if (long_f) begin
      push_word(w, 4);
      push_word(h, 4);
      push_word(1, 2);
      push_word(depth, 2);
      push_noise(24);
    end else begin
      push_word(w, 2);
      push_word(h, 2);
      push_word(1, 2);
      push_word(depth, 2);
    end
    // an offset inside the palette stops the file at the depth field
    if (depth == DEPTH_PAL && off >= pend) push_noise(pend - hend);
    if (off > pend) push_noise(off - pend);
    row_data = w * ((depth == DEPTH_TRUE) ? 3 : 1);
    total = ((row_data + 3) & ~3) * ((h < 0) ? -h : h);
    if (pix_keep >= 0 && pix_keep < total) total = pix_keep;
    push_noise(total);
    push_noise(junk);
    file_cnt++;
  endfunction

  function automatic void build_random_true_color();
    bit long_f;
    int w;
    int h;
    int keep;
    long_f = $urandom_range(0, 1);
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 3);
    if ($urandom_range(0, 1)) h = -h;
    keep = -1;
    // a few files are cut short or broken, so the next file start lands mid-file
    case ($urandom_range(0, 9))
      0: keep = $urandom_range(0, 12);
      1: begin
        build_file(long_f, w, h, DEPTH_TRUE, long_f ? INFO_LONG : INFO_SHORT,
                   0, 0, $urandom_range(1, 2), 0, $urandom_range(0, 4));
        return;
      end
      default: ;
    endcase
    build_file(long_f, w, h, DEPTH_TRUE, long_f ? INFO_LONG : INFO_SHORT,
               $urandom_range(0, 3), 0, 0, keep, $urandom_range(0, 3));
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reporting
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: send pending bytes in bursts with random gaps, predict on acceptance.
  // ---------------------------------------------------------------------------
  int             burst_left;
  int             gap_left;
  file_byte_t     next_byte;
  decode_result_t accepted_result;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      // a request taken at this edge moves the shadow decoder forward
      if (in_bus.valid && in_bus.ready) begin
        bytes_sent++;
        if (predict_byte(in_bus.byte_value, in_bus.file_start, accepted_result))
          expected_results.push_back(accepted_result);
      end
      // hold the current request until it is taken
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_byte = pending_bytes.pop_front();
          in_bus.byte_value <= next_byte.value;
          in_bus.file_start <= next_byte.first;
          in_bus.valid      <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern in one of three modes, redrawn at random, plus one long
  // hold-off on request so the decoder backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int ready_cycle;
  int ready_mode;
  int hold_cnt;
  bit hold_go;
  bit hold_done;

  always @(posedge clk) begin
    ready_cycle++;
    if (ready_cycle % 64 == 0) ready_mode = $urandom_range(0, 2);
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_bus.ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= $urandom_range(0, 1);
        default: out_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest prediction.
  // ---------------------------------------------------------------------------
  decode_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_bus.result_kind !== want.kind) report("kind", out_bus.result_kind, want.kind);
        if (out_bus.red !== want.red) report("red", out_bus.red, want.red);
        if (out_bus.green !== want.green) report("green", out_bus.green, want.green);
        if (out_bus.blue !== want.blue) report("blue", out_bus.blue, want.blue);
        if (out_bus.column !== want.column) report("column", out_bus.column, want.column);
        if (out_bus.file_row !== want.file_row)
          report("file_row", out_bus.file_row, want.file_row);
        if (out_bus.top_down !== want.top_down)
          report("top_down", out_bus.top_down, want.top_down);
        if (out_bus.last_pixel !== want.last_pixel)
          report("last_pixel", out_bus.last_pixel, want.last_pixel);
        if (out_bus.error_code !== want.error_code)
          report("error_code", out_bus.error_code, want.error_code);
        if (want.kind == KIND_ERROR) error_cnt++;
        else pixel_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (bytes_sent != bytes_queued || expected_results.size() != 0)
      @(posedge clk);
    // allow the pipeline to drain bytes that give no result
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep_index(input logic v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    shadow_keep_index = v;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.byte_value = '0;
    in_bus.file_start = 1'b0;
    out_bus.ready = 1'b0;
    restart_parse();
    shadow_phase = PARSE_IDLE;
    shadow_keep_index = 1'b0;
    for (int i = 0; i < PAL_ENTRIES; i++) shadow_palette[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bytes before any file, every error, size extremes, restarts.
    push_noise(3);
    build_file(1, 2, 2, DEPTH_TRUE, INFO_LONG, 0, 0, 1, 0, 2);          // bad 'B'
    build_file(1, 2, 2, DEPTH_TRUE, INFO_LONG, 0, 0, 2, 0, 2);          // bad 'M'
    build_file(1, 2, 2, DEPTH_TRUE, 20, 0, 0, 0, 0, 2);                 // bad info size
    build_file(1, 2, 2, 16, INFO_LONG, 0, 0, 0, 0, 2);                  // bad depth
    build_file(1, 2, 2, DEPTH_TRUE, INFO_LONG, 0, -1, 0, 0, 2);         // offset in header
    build_file(0, 2, 2, DEPTH_PAL, INFO_SHORT, 0, -1, 0, 0, 2);         // offset in palette
    build_file(1, 0, 2, DEPTH_TRUE, INFO_LONG, 0, 0, 0, 0, 1);          // zero width
    build_file(1, 4097, 1, DEPTH_TRUE, INFO_LONG, 0, 0, 0, 0, 1);       // width too big
    build_file(1, -1, 1, DEPTH_TRUE, INFO_LONG, 0, 0, 0, 0, 1);         // negative width
    build_file(1, 3, 0, DEPTH_TRUE, INFO_LONG, 0, 0, 0, 0, 1);          // zero height
    build_file(1, 3, -4097, DEPTH_TRUE, INFO_LONG, 0, 0, 0, 0, 1);      // height too big
    build_file(0, -3, 2, DEPTH_TRUE, INFO_SHORT, 0, 0, 0, 0, 1);        // short negative width
    build_file(1, 4096, -4096, DEPTH_TRUE, INFO_LONG, 0, 0, 0, 30, 0);  // largest, cut off
    build_file(0, 4096, 4096, DEPTH_TRUE, INFO_SHORT, 1, 0, 0, 9, 0);   // largest, short
    build_file(1, 3, 2, DEPTH_TRUE, INFO_LONG, 0, 0, 0, -1, 3);
    build_file(0, 1, -1, DEPTH_TRUE, INFO_SHORT, 0, 0, 0, -1, 3);
    for (int i = 0; i < 2; i++) build_random_true_color();
    // palette lookup for a short depth-8 file, cut off inside its pixel data
    build_file(0, 5, 3, DEPTH_PAL, INFO_SHORT, 2, 0, 0, 12, 0);
    wait_idle();

    // Palette index output switched on between files, then noise and a true-color file.
    write_keep_index(1'b1);
    push_noise(16);
    build_random_true_color();
    wait_idle();

    // Back to color output, with a long receiver hold-off.
    write_keep_index(1'b0);
    for (int i = 0; i < 3; i++) build_random_true_color();
    hold_go = 1'b1;
    wait_idle();
    repeat (20) @(posedge clk);

    $display("sent %0d bytes in %0d files: %0d pixel and %0d error results checked",
             bytes_sent, file_cnt, pixel_cnt, error_cnt);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bsd_pkg.sv
hdl/bsd_if.sv
hdl/bsd_palette.sv
hdl/bsd_parser.sv
hdl/bmp_stream_decoder.sv
dv/bmp_stream_decoder_tb.sv
